/* rtl/euler_to_rotation_matrix_defines.svh */
// assertion helpers for the rotation matrix block
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH

// implication checked while out of reset
`define E2R_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("e2r check failed");

// implication checked on every edge, reset included
`define E2R_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("e2r reset check failed");

`endif

/* rtl/e2r_pkg.sv */
`timescale 1ns / 1ps
package e2r_pkg;

    localparam int unsigned PW = 34;   // cordic x, y, z width (q2.30 plus margin)
    localparam int unsigned SW = 22;   // sine / cosine width (q20)
    localparam int unsigned MW = 44;   // two-factor product width
    localparam int unsigned TW = 66;   // three-factor term width (q60)

    typedef logic signed [PW-1:0] t_cval;
    typedef logic signed [SW-1:0] t_trig;
    typedef logic signed [TW-1:0] t_term;

    localparam t_cval GAIN_Q30 = 34'sd652032874;
    localparam t_trig UNIT_Q20 = 22'sd1048576;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] v;
        begin
            case (i)
                0:  v = 32'd536870912;
                1:  v = 32'd316933406;
                2:  v = 32'd167458907;
                3:  v = 32'd85004756;
                4:  v = 32'd42667331;
                5:  v = 32'd21354465;
                6:  v = 32'd10679838;
                7:  v = 32'd5340245;
                8:  v = 32'd2670163;
                9:  v = 32'd1335087;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41722;
                15: v = 32'd20861;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2608;
                19: v = 32'd1304;
                20: v = 32'd652;
                21: v = 32'd326;
                22: v = 32'd163;
                23: v = 32'd81;
                24: v = 32'd41;
                25: v = 32'd20;
                26: v = 32'd10;
                27: v = 32'd5;
                28: v = 32'd3;
                29: v = 32'd1;
                30: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/euler_to_rotation_matrix.sv */
`timescale 1ns / 1ps
// an accepted angle word passes the phase, cordic, fold/round, product and output stages
// throughput: one word per cycle unless stalled; each CORDIC cell and product stage likewise
// a stalled result holds the unbroken run of full stages behind it; empty stages keep filling
// reset (synchronous, active low) clears every stage valid bit; data registers are not reset
module euler_to_rotation_matrix
    import e2r_pkg::*;
#(
    parameter int unsigned ANGLE_BITS     = 16,
    parameter int unsigned COEF_FRAC_BITS = 14,
    parameter int unsigned CORDIC_STEPS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22
);

    // stage map: 0 phase, 1..N cordic cells, N+1 fold/round, N+2..N+4 products, N+5 output
    localparam int unsigned NS = CORDIC_STEPS + 6;
    localparam int unsigned TS = CORDIC_STEPS + 2;   // first product stage

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_en;

    // a stage moves when it is empty or some stage after it is empty or the output drains
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (w_en[k]) n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
            else         n_vld[k] = r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NS-1];

    // sine and cosine of each angle through its own cell chain
    t_trig w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_scx (
        .i_clk(i_clk), .i_en(w_en[TS-1:0]), .i_angle(i_angle_x),
        .o_sin(w_sx), .o_cos(w_cx));
    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_scy (
        .i_clk(i_clk), .i_en(w_en[TS-1:0]), .i_angle(i_angle_y),
        .o_sin(w_sy), .o_cos(w_cy));
    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_scz (
        .i_clk(i_clk), .i_en(w_en[TS-1:0]), .i_angle(i_angle_z),
        .o_sin(w_sz), .o_cos(w_cz));

    // negated factors for the difference terms and for m20
    t_trig w_nsy, w_nsz, w_ncz;
    assign w_nsy = -w_sy;
    assign w_nsz = -w_sz;
    assign w_ncz = -w_cz;

    // every entry is a sum of two triple products in q60; shorter terms carry unit factors
    logic [3:0] w_pen;
    assign w_pen = w_en[NS-1:TS];

    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m00 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_cz), .i_b1(w_cy), .i_c1(UNIT_Q20),
        .i_a2('0), .i_b2('0), .i_c2('0), .o_m(o_m00));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m01 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_cz), .i_b1(w_sy), .i_c1(w_sx),
        .i_a2(w_nsz), .i_b2(w_cx), .i_c2(UNIT_Q20), .o_m(o_m01));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m02 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_cz), .i_b1(w_sy), .i_c1(w_cx),
        .i_a2(w_sz), .i_b2(w_sx), .i_c2(UNIT_Q20), .o_m(o_m02));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m10 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_sz), .i_b1(w_cy), .i_c1(UNIT_Q20),
        .i_a2('0), .i_b2('0), .i_c2('0), .o_m(o_m10));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m11 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_sz), .i_b1(w_sy), .i_c1(w_sx),
        .i_a2(w_cz), .i_b2(w_cx), .i_c2(UNIT_Q20), .o_m(o_m11));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m12 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_sz), .i_b1(w_sy), .i_c1(w_cx),
        .i_a2(w_ncz), .i_b2(w_sx), .i_c2(UNIT_Q20), .o_m(o_m12));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m20 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_nsy), .i_b1(UNIT_Q20), .i_c1(UNIT_Q20),
        .i_a2('0), .i_b2('0), .i_c2('0), .o_m(o_m20));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m21 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_cy), .i_b1(w_sx), .i_c1(UNIT_Q20),
        .i_a2('0), .i_b2('0), .i_c2('0), .o_m(o_m21));
    e2r_entry #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_m22 (.i_clk(i_clk), .i_en(w_pen),
        .i_a1(w_cy), .i_b1(w_cx), .i_c1(UNIT_Q20),
        .i_a2('0), .i_b2('0), .i_c2('0), .o_m(o_m22));

endmodule

/* rtl/e2r_cell.sv */
`timescale 1ns / 1ps
module e2r_cell
    import e2r_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_cval      i_x,
    input  t_cval      i_y,
    input  t_cval      i_z,
    input  logic [1:0] i_quad,
    output t_cval      o_x,
    output t_cval      o_y,
    output t_cval      o_z,
    output logic [1:0] o_quad
);

    localparam t_cval ANG = t_cval'(atan_turn(STEP));

    t_cval w_dx, w_dy;
    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[PW-1]) begin
                o_x <= i_x - w_dx;
                o_y <= i_y + w_dy;
                o_z <= i_z - ANG;
            end else begin
                o_x <= i_x + w_dx;
                o_y <= i_y - w_dy;
                o_z <= i_z + ANG;
            end
            o_quad <= i_quad;
        end
    end

endmodule

/* rtl/e2r_sincos.sv */
`timescale 1ns / 1ps
module e2r_sincos
    import e2r_pkg::*;
#(
    parameter int unsigned ANGLE_BITS   = 16,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic [CORDIC_STEPS+1:0] i_en,
    input  logic [15:0]           i_angle,
    output t_trig                 o_sin,
    output t_trig                 o_cos
);

    logic [31:0] w_phase;
    assign w_phase = 32'({16'd0, i_angle} << (32 - ANGLE_BITS));

    t_cval      r_x0, r_y0, r_z0;
    logic [1:0] r_q0;

    t_cval      w_x [CORDIC_STEPS+1];
    t_cval      w_y [CORDIC_STEPS+1];
    t_cval      w_z [CORDIC_STEPS+1];
    logic [1:0] w_q [CORDIC_STEPS+1];

    // stage 0: phase split into quadrant and first-quadrant angle
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x0 <= GAIN_Q30;
            r_y0 <= '0;
            r_z0 <= t_cval'({4'd0, w_phase[29:0]});
            r_q0 <= w_phase[31:30];
        end
    end

    assign w_x[0] = r_x0;
    assign w_y[0] = r_y0;
    assign w_z[0] = r_z0;
    assign w_q[0] = r_q0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        e2r_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en[g+1]),
            .i_x   (w_x[g]),
            .i_y   (w_y[g]),
            .i_z   (w_z[g]),
            .i_quad(w_q[g]),
            .o_x   (w_x[g+1]),
            .o_y   (w_y[g+1]),
            .o_z   (w_z[g+1]),
            .o_quad(w_q[g+1])
        );
    end

    t_cval w_c, w_s, w_cr, w_sr;
    always_comb begin
        case (w_q[CORDIC_STEPS])
            2'd0:    begin w_c = w_x[CORDIC_STEPS];  w_s = w_y[CORDIC_STEPS];  end
            2'd1:    begin w_c = -w_y[CORDIC_STEPS]; w_s = w_x[CORDIC_STEPS];  end
            2'd2:    begin w_c = -w_x[CORDIC_STEPS]; w_s = -w_y[CORDIC_STEPS]; end
            default: begin w_c = w_y[CORDIC_STEPS];  w_s = -w_x[CORDIC_STEPS]; end
        endcase
    end
    assign w_cr = (w_c + t_cval'(512)) >>> 10;
    assign w_sr = (w_s + t_cval'(512)) >>> 10;

    always_ff @(posedge i_clk) begin
        if (i_en[CORDIC_STEPS+1]) begin
            o_cos <= t_trig'(w_cr);
            o_sin <= t_trig'(w_sr);
        end
    end

endmodule

/* rtl/e2r_term.sv */
`timescale 1ns / 1ps
module e2r_term
    import e2r_pkg::*;
(
    input  logic       i_clk,
    input  logic [2:0] i_en,
    input  t_trig      i_a,
    input  t_trig      i_b,
    input  t_trig      i_c,
    output t_term      o_t
);

    logic signed [MW-1:0]   r_ab;
    t_trig                  r_c;
    logic signed [MW:0]     r_lo;
    logic signed [MW-1:0]   r_hi;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ab <= i_a * i_b;
            r_c  <= i_c;
        end
        // split the wide product into two narrow partials
        if (i_en[1]) begin
            r_lo <= $signed({1'b0, r_ab[SW-1:0]}) * r_c;
            r_hi <= $signed(r_ab[MW-1:SW]) * r_c;
        end
        if (i_en[2]) begin
            o_t <= (t_term'(r_hi) <<< SW) + t_term'(r_lo);
        end
    end

endmodule

/* rtl/e2r_entry.sv */
`timescale 1ns / 1ps
module e2r_entry
    import e2r_pkg::*;
#(
    parameter int unsigned COEF_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic [3:0]        i_en,
    input  t_trig             i_a1,
    input  t_trig             i_b1,
    input  t_trig             i_c1,
    input  t_trig             i_a2,
    input  t_trig             i_b2,
    input  t_trig             i_c2,
    output logic signed [15:0] o_m
);

    localparam int unsigned SH = 60 - COEF_FRAC_BITS;
    localparam logic signed [TW:0] HI_LIM = (COEF_FRAC_BITS >= 15) ?
        (TW+1)'(32767) : ((TW+1)'(1) <<< COEF_FRAC_BITS);
    localparam logic signed [TW:0] LO_LIM = -HI_LIM - ((COEF_FRAC_BITS >= 15) ?
        (TW+1)'(1) : (TW+1)'(0));
    localparam logic signed [TW:0] HALF = (TW+1)'(1) <<< (SH - 1);

    t_term w_t1, w_t2;

    e2r_term u_t1 (.i_clk(i_clk), .i_en(i_en[2:0]),
                   .i_a(i_a1), .i_b(i_b1), .i_c(i_c1), .o_t(w_t1));
    e2r_term u_t2 (.i_clk(i_clk), .i_en(i_en[2:0]),
                   .i_a(i_a2), .i_b(i_b2), .i_c(i_c2), .o_t(w_t2));

    logic signed [TW:0] w_r;
    assign w_r = ((TW+1)'(w_t1) + (TW+1)'(w_t2) + HALF) >>> SH;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            if (w_r > HI_LIM)      o_m <= 16'(HI_LIM);
            else if (w_r < LO_LIM) o_m <= 16'(LO_LIM);
            else                   o_m <= 16'(w_r);
        end
    end

endmodule

/* rtl/e2r_checker.sv */
`timescale 1ns / 1ps
`include "euler_to_rotation_matrix_defines.svh"
module e2r_checker #(
    parameter int unsigned COEF_FRAC_BITS = 14
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_m00,
    input logic signed [15:0] o_m20,
    input logic signed [15:0] o_m22
);

    localparam int HI = (COEF_FRAC_BITS >= 15) ? 32767 : (1 << COEF_FRAC_BITS);
    localparam int LO = (COEF_FRAC_BITS >= 15) ? -32768 : -HI;

    logic w_in_range;
    assign w_in_range = (32'(o_m00) <= HI) && (32'(o_m00) >= LO)
                     && (32'(o_m20) <= HI) && (32'(o_m20) >= LO)
                     && (32'(o_m22) <= HI) && (32'(o_m22) >= LO);

    `E2R_ASSERT_ALWAYS(a_rst_clears, $past(!i_rst_n), !o_valid)
    `E2R_ASSERT(a_stall_holds, $past(o_valid && !i_ready), o_valid && $stable(o_m00))
    `E2R_ASSERT(a_range, o_valid, w_in_range)

endmodule

bind euler_to_rotation_matrix e2r_checker #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_e2r_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_m00(o_m00), .o_m20(o_m20), .o_m22(o_m22));

/* tb/euler_to_rotation_matrix_checker.sv */
`timescale 1ns / 1ps
module euler_to_rotation_matrix_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    input  logic               i_out_valid,
    input  logic               i_ready,
    input  logic signed [15:0] i_m [9],
    output int                 o_errors,
    output int                 o_pending
);

    typedef logic signed [15:0] t_entry;
    typedef struct {
        t_entry e [9];
    } t_matrix;

    t_matrix matrix_q [$];

    // atan(2^-i) in 2^-32 turn units
    longint atan_tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861};

    function automatic void trig_q20(input logic [15:0] ang, output longint sn,
                                     output longint cs);
        logic [31:0] ph;
        longint x, y, z, dx, dy, c, s;
        ph = {ang, 16'h0};
        x = 652032874;
        y = 0;
        z = longint'(ph[29:0]);
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        case (ph[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cs = (c + 512) >>> 10;
        sn = (s + 512) >>> 10;
    endfunction

    // q60 term to saturated q1.14
    function automatic t_entry round_entry(input logic signed [79:0] v);
        logic signed [79:0] r;
        r = (v + (80'sd1 << 45)) >>> 46;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return t_entry'(r[15:0]);
    endfunction

    function automatic t_matrix rotation_of(input logic [15:0] ax, input logic [15:0] ay,
                                            input logic [15:0] az);
        t_matrix m;
        longint sx, cx, sy, cy, sz, cz;
        logic signed [79:0] u, a, b, c, d, e, f;
        trig_q20(ax, sx, cx);
        trig_q20(ay, sy, cy);
        trig_q20(az, sz, cz);
        u = 80'sd1 << 20;
        a = sx; b = cx; c = sy; d = cy; e = sz; f = cz;
        m.e[0] = round_entry(f * d * u);
        m.e[1] = round_entry(f * c * a - e * b * u);
        m.e[2] = round_entry(f * c * b + e * a * u);
        m.e[3] = round_entry(e * d * u);
        m.e[4] = round_entry(e * c * a + f * b * u);
        m.e[5] = round_entry(e * c * b - f * a * u);
        m.e[6] = round_entry(-c * u * u);
        m.e[7] = round_entry(d * a * u);
        m.e[8] = round_entry(d * b * u);
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_matrix want;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && i_in_ready)
                matrix_q.insert(matrix_q.size(),
                                rotation_of(i_angle_x, i_angle_y, i_angle_z));
            if (i_out_valid && i_ready) begin
                if (matrix_q.size() == 0) begin
                    $display("%0t: unexpected result word", $time);
                    bad++;
                end else begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (want.e[k] !== i_m[k]) begin
                            $display("%0t: m%0d%0d expected %0d got %0d", $time,
                                     k / 3, k % 3, want.e[k], i_m[k]);
                            bad++;
                        end
                end
            end
            if (bad != 0)
                o_errors <= o_errors + bad;
            o_pending <= matrix_q.size();
        end
    end

endmodule

/* tb/euler_to_rotation_matrix_tb.sv */
`timescale 1ns / 1ps
module euler_to_rotation_matrix_tb;

    localparam int LATENCY = 22;
    localparam int STALL_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] ang_x = '0, ang_y = '0, ang_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] m [9];
    int                 errors, pending;

    // rates in percent, changed per phase
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    always #10 clk = ~clk;

    euler_to_rotation_matrix u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_angle_x(ang_x), .i_angle_y(ang_y), .i_angle_z(ang_z),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_m00(m[0]), .o_m01(m[1]), .o_m02(m[2]),
        .o_m10(m[3]), .o_m11(m[4]), .o_m12(m[5]),
        .o_m20(m[6]), .o_m21(m[7]), .o_m22(m[8])
    );

    euler_to_rotation_matrix_checker u_check (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_angle_x(ang_x), .i_angle_y(ang_y), .i_angle_z(ang_z),
        .i_out_valid(out_valid), .i_ready(out_ready), .i_m(m),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stall, or a long hold-off when asked
    always @(negedge clk) begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog on cycles with no word moving
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // offer one angle word, with a random gap first, and wait for acceptance
    task automatic send_word(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ang_x <= x;
        ang_y <= y;
        ang_z <= z;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // random angle: corners, quadrant edges or anything
    function automatic logic [15:0] pick_angle();
        logic [15:0] quads [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                   16'h7FFF, 16'hFFFF, 16'h0001, 16'h3FFF};
        case ($urandom_range(3))
            0: return quads[$urandom_range(7)];
            1: return quads[$urandom_range(7)] + 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // input goes idle, then wait for every result
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        logic [15:0] corner [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                    16'h7FFF, 16'h8001};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // quadrant corners and range limits on every axis
        for (int i = 0; i < 6; i++)
            send_word(corner[i], corner[(i + 1) % 6], corner[(i + 3) % 6]);
        send_word(16'h2000, 16'h4000, 16'hE000);   // gimbal lock, sy at one
        send_word(16'h5555, 16'hAAAA, 16'hFFFF);
        send_word(16'hAAAA, 16'h5555, 16'h0000);
        for (int i = 0; i < 8; i++)
            send_word(pick_angle(), pick_angle(), pick_angle());

        // phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1) ? 56 : (ph == 3) ? 8 : 0;
            recv_stall = (ph == 2) ? 56 : (ph == 3) ? 8 : 0;
            for (int n = 0; n < 210; n++)
                send_word(pick_angle(), pick_angle(), pick_angle());
            // sender pauses until every result is back
            drain();
        end

        // long receiver hold-off while words keep coming, fills the pipe
        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 40; n++)
                send_word(pick_angle(), pick_angle(), pick_angle());
        join
        drain();

        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
